### sv/rtr_pkg.sv
// ----------------------------------------------------------------------------
// rtr_pkg
// Shared types and constants for the RTP timestamp rebaser.
// ----------------------------------------------------------------------------
`default_nettype none

package rtr_pkg;

  typedef enum logic [1:0] {
    FUNC_CONVERT = 2'd0,
    FUNC_SYNC_SR = 2'd1,
    FUNC_SYNC_TS = 2'd2,
    FUNC_CLEAR   = 2'd3
  } func_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV1,
    ST_MUL1,
    ST_DIV2,
    ST_MUL2,
    ST_SUM,
    ST_FIN
  } state_t;

  localparam logic        REG_CLOCK_RATE = 1'b0;
  localparam logic [30:0] RATE_RESET     = 31'd90000;
  localparam logic [7:0]  SR_TYPE        = 8'd200;
  localparam logic [15:0] SR_MIN_LEN     = 16'd20;
  localparam logic [31:0] MS_PER_S       = 32'd1000;
  localparam logic [9:0]  MS_PER_S_10    = 10'd1000;
  localparam logic [31:0] ALL_ONES       = 32'hFFFF_FFFF;
  localparam logic [5:0]  WORD_BITS      = 6'd32;
  // fraction ms (10 bits) times a 31-bit rate
  localparam logic [5:0]  WALL_PROD_BITS = 6'd41;

endpackage

`default_nettype wire

### sv/rtr_in_if.sv
// ----------------------------------------------------------------------------
// rtr_in_if
// Input item channel: valid/ready handshake with the request fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtr_in_if
  import rtr_pkg::*;
;
  logic        valid;
  logic        ready;
  func_t       func;
  logic [31:0] timestamp;
  logic        use_wall_clock;
  logic [31:0] ntp_seconds;
  logic [31:0] ntp_fraction;
  logic [7:0]  packet_type;
  logic [15:0] packet_length;

  modport source (
    output valid, func, timestamp, use_wall_clock, ntp_seconds, ntp_fraction,
           packet_type, packet_length,
    input  ready
  );

  modport sink (
    input  valid, func, timestamp, use_wall_clock, ntp_seconds, ntp_fraction,
           packet_type, packet_length,
    output ready
  );
endinterface

`default_nettype wire

### sv/rtr_out_if.sv
// ----------------------------------------------------------------------------
// rtr_out_if
// Result item channel: valid/ready handshake with the result fields.
// ----------------------------------------------------------------------------
`default_nettype none

interface rtr_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_value;
  logic        initiated;

  modport source (
    output valid, result_value, initiated,
    input  ready
  );

  modport sink (
    input  valid, result_value, initiated,
    output ready
  );
endinterface

`default_nettype wire

### sv/rtp_timestamp_rebaser_top.sv
// Clears, rejected reports, rate-zero syncs and unscaled converts go straight to ST_FIN;
//   syncs and rescaled converts pass ST_DIV1, ST_MUL1, ST_DIV2, ST_MUL2 and ST_SUM first,
//   using the shared bit-serial divider and shift-add multiplier; the second division
//   runs over D bits, D = 41 for syncs, 31 + clog2(PIPELINE_RATE+1) for converts.
// One item in flight: ST_FIN waits while the output is full, then loads the result.
// Reset (rst, synchronous): clock_rate 90000, offset 0, initiated flag clear.
// ----------------------------------------------------------------------------
// rtp_timestamp_rebaser_top
// Maps RTP timestamps to a pipeline time base using an offset taken from
// sender reports or plain syncs; one shared serial divider and multiplier.
// ----------------------------------------------------------------------------
`default_nettype none

module rtp_timestamp_rebaser_top
  import rtr_pkg::*;
#(
  parameter int PIPELINE_RATE = 1000
) (
  input  wire logic        clk,
  input  wire logic        rst,
  rtr_in_if.sink           in_item,
  rtr_out_if.source        out_item,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic      [31:0] prdata,
  output logic             pready
);

  localparam int          PW        = $clog2(PIPELINE_RATE + 1);
  localparam logic [5:0]  FRAC_BITS = 6'(31 + PW);
  localparam logic [31:0] PRATE     = 32'(PIPELINE_RATE);

  state_t state, state_next;

  logic [30:0] clock_rate;
  logic [31:0] offset;
  logic        offset_valid;
  logic        out_valid;
  logic [31:0] out_value;
  logic        out_init;

  logic [31:0] num;
  logic [31:0] rem;
  logic [31:0] q;
  logic [31:0] q1;
  logic [31:0] r1;
  logic [63:0] acc;
  logic [5:0]  cnt;
  logic        op_sync;
  logic [7:0]  wsec;
  logic [9:0]  fms;
  logic [31:0] res;

  // config port
  logic cfg_wr;
  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;
  assign prdata = (paddr[2] == REG_CLOCK_RATE) ? {1'b0, clock_rate} : 32'd0;

  // item decode
  logic        accept;
  logic        rate_zero;
  logic        is_prate;
  logic        report_ok;
  logic [31:0] ts_delta;
  logic [25:0] frac_prod;
  logic        last;
  logic        load_out;

  assign in_item.ready = (state == ST_IDLE);
  assign accept        = in_item.valid && in_item.ready;
  assign rate_zero     = (clock_rate == 31'd0);
  assign is_prate      = ({1'b0, clock_rate} == PRATE);
  assign report_ok     = (in_item.packet_length > SR_MIN_LEN) &&
                         (in_item.packet_type == SR_TYPE) && !rate_zero;
  assign ts_delta      = in_item.timestamp - offset;
  assign frac_prod     = {10'd0, in_item.ntp_fraction[31:16]} * {16'd0, MS_PER_S_10};
  assign last          = (cnt == 6'd1);
  assign load_out      = (state == ST_FIN) && (!out_valid || out_item.ready);

  // serial divider step
  logic [31:0] divisor;
  logic        div_bit;
  logic [31:0] trial;
  logic        div_ge;
  logic [5:0]  idx;

  assign idx     = cnt - 6'd1;
  assign divisor = (state == ST_DIV2 && op_sync) ? MS_PER_S : {1'b0, clock_rate};
  assign div_bit = (state == ST_DIV1) ? num[idx[4:0]] : acc[idx];
  assign trial   = {rem[30:0], div_bit};
  assign div_ge  = (trial >= divisor);

  // offset split from the two division passes
  logic        borrow;
  logic [31:0] osec;
  logic [31:0] ofr;

  assign borrow = (r1 < q);
  assign osec   = q1 - {24'd0, wsec} - {31'd0, borrow};
  assign ofr    = borrow ? ({1'b0, clock_rate} + r1 - q) : (r1 - q);

  // shift-add multiplier step, multiplier bits taken MSB first
  logic [31:0] mul_a;
  logic [31:0] mul_b;
  logic [63:0] acc_next;

  always_comb begin
    if (state == ST_MUL1) begin
      mul_a = op_sync ? {1'b0, clock_rate} : rem;
      mul_b = op_sync ? {22'd0, fms} : PRATE;
    end else begin
      mul_a = op_sync ? osec : q1;
      mul_b = op_sync ? {1'b0, clock_rate} : PRATE;
    end
  end

  assign acc_next = {acc[62:0], 1'b0} + (mul_b[idx[4:0]] ? {32'd0, mul_a} : 64'd0);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (in_item.func)
            FUNC_CONVERT: begin
              state_next = (rate_zero || is_prate || !in_item.use_wall_clock) ?
                           ST_FIN : ST_DIV1;
            end
            FUNC_SYNC_SR: state_next = report_ok ? ST_DIV1 : ST_FIN;
            FUNC_SYNC_TS: state_next = rate_zero ? ST_FIN : ST_DIV1;
            FUNC_CLEAR:   state_next = ST_FIN;
          endcase
        end
      end
      ST_DIV1: if (last) state_next = ST_MUL1;
      ST_MUL1: if (last) state_next = ST_DIV2;
      ST_DIV2: if (last) state_next = ST_MUL2;
      ST_MUL2: if (last) state_next = ST_SUM;
      ST_SUM:  state_next = ST_FIN;
      ST_FIN:  if (load_out) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  // control and architectural state
  always_ff @(posedge clk) begin
    if (rst) begin
      clock_rate   <= RATE_RESET;
      offset       <= 32'd0;
      offset_valid <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (cfg_wr && paddr[2] == REG_CLOCK_RATE) begin
        clock_rate <= pwdata[30:0];
      end
      if (accept && in_item.func == FUNC_SYNC_TS && rate_zero) begin
        offset <= ALL_ONES;
      end
      if (accept && in_item.func == FUNC_CLEAR) begin
        offset_valid <= 1'b0;
      end
      if (state == ST_SUM && op_sync) begin
        offset       <= acc[31:0] + ofr;
        offset_valid <= 1'b1;
      end
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_item.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // datapath
  always_ff @(posedge clk) begin
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          num     <= (in_item.func == FUNC_CONVERT) ? ts_delta : in_item.timestamp;
          rem     <= 32'd0;
          q       <= 32'd0;
          cnt     <= WORD_BITS;
          op_sync <= (in_item.func != FUNC_CONVERT);
          res     <= (in_item.func != FUNC_CONVERT) ? 32'd0 :
                     (rate_zero ? ALL_ONES : ts_delta);
          if (in_item.func == FUNC_SYNC_SR) begin
            wsec <= in_item.ntp_seconds[7:0];
            fms  <= frac_prod[25:16];
          end else begin
            wsec <= 8'd0;
            fms  <= 10'd0;
          end
        end
      end
      ST_DIV1, ST_DIV2: begin
        rem <= div_ge ? (trial - divisor) : trial;
        q   <= {q[30:0], div_ge};
        cnt <= last ? WORD_BITS : (cnt - 6'd1);
        if (last) begin
          acc <= 64'd0;
        end
      end
      ST_MUL1, ST_MUL2: begin
        acc <= acc_next;
        if (state == ST_MUL1) begin
          // hold the first pass quotient and remainder
          q1 <= q;
          r1 <= rem;
        end
        if (state == ST_MUL1 && last) begin
          rem <= 32'd0;
          q   <= 32'd0;
          cnt <= op_sync ? WALL_PROD_BITS : FRAC_BITS;
        end else begin
          cnt <= cnt - 6'd1;
        end
      end
      ST_SUM: begin
        if (!op_sync) begin
          res <= acc[31:0] + q;
        end
      end
      ST_FIN: begin
        if (load_out) begin
          out_value <= res;
          out_init  <= offset_valid;
        end
      end
      default: ;
    endcase
  end

  assign out_item.valid        = out_valid;
  assign out_item.result_value = out_value;
  assign out_item.initiated    = out_init;

endmodule

`default_nettype wire
